// ===== src/bnh_pkg.sv =====
package bnh_pkg;

    // width of an internal pattern length, covers lengths up to thirty-one
    localparam int LEN_W = 5;
    localparam int CFG_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int QLEN_W = 4;
    localparam int QPAT_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd1;

    localparam logic [CFG_W-1:0] MIN_LEN_RST = 4'd1;
    localparam logic [CFG_W-1:0] MAX_LEN_RST = 4'd12;

    localparam logic OP_SHIFT = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INC_RD,
        S_INC_WR,
        S_Q_RD,
        S_Q_OUT
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load_shift;
        logic load_query;
        logic inc_rd;
        logic inc_wr;
        logic q_rd;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic len_ok;
        logic len_last;
        logic out_busy;
    } t_dp_stat;

endpackage

// ===== src/bnh_ram.sv =====
module bnh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bnh_ctrl.sv =====
module bnh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_opcode,
    input  bnh_pkg::t_dp_stat i_stat,
    output logic              o_ready,
    output bnh_pkg::t_dp_cmd  o_cmd
);

    import bnh_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_opcode == OP_QUERY) ? S_Q_RD : S_INC_RD;
                end
            end
            S_INC_RD: begin
                n_state = i_stat.len_ok ? S_INC_WR : S_IDLE;
            end
            S_INC_WR: begin
                n_state = i_stat.len_last ? S_IDLE : S_INC_RD;
            end
            S_Q_RD: begin
                n_state = S_Q_OUT;
            end
            S_Q_OUT: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                o_ready           = 1'b1;
                o_cmd.load_shift  = i_valid && (i_opcode == OP_SHIFT);
                o_cmd.load_query  = i_valid && (i_opcode == OP_QUERY);
            end
            S_INC_RD: begin
                o_cmd.inc_rd = i_stat.len_ok;
            end
            S_INC_WR: begin
                o_cmd.inc_wr = 1'b1;
            end
            S_Q_RD: begin
                o_cmd.q_rd = 1'b1;
            end
            S_Q_OUT: begin
                o_cmd.out_load = !i_stat.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/bnh_datapath.sv =====
module bnh_datapath #(
    parameter int MAX_LEN = 12,
    parameter int COUNT_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bnh_pkg::t_dp_cmd                 i_cmd,
    output bnh_pkg::t_dp_stat                o_stat,
    input  logic                             i_cfg_valid,
    input  logic [bnh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bnh_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             i_stream_bit,
    input  logic [bnh_pkg::QLEN_W-1:0]       i_query_len,
    input  logic [bnh_pkg::QPAT_W-1:0]       i_query_pattern,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [COUNT_BITS-1:0]            o_pattern_count
);

    import bnh_pkg::*;

    localparam int AW = MAX_LEN + 1;
    localparam int DEPTH = 1 << AW;
    localparam int SW = $clog2(MAX_LEN + 1);

    logic [CFG_W-1:0]      r_min_len;
    logic [CFG_W-1:0]      r_max_len;
    logic [MAX_LEN-1:0]    r_window;
    logic [SW-1:0]         r_seen;
    logic [LEN_W-1:0]      r_len;
    logic [LEN_W-1:0]      r_end;
    logic [AW-1:0]         r_qaddr;
    logic                  r_q_in;
    logic [AW-1:0]         r_clr_addr;
    logic                  r_out_valid;
    logic [COUNT_BITS-1:0] r_count;

    logic [MAX_LEN-1:0]    n_window;
    logic [MAX_LEN:0]      win_ext;
    logic [SW-1:0]         n_seen;
    logic [LEN_W-1:0]      lo;
    logic [LEN_W-1:0]      hi;
    logic [LEN_W-1:0]      seen_len;
    logic [LEN_W-1:0]      qlen;

    logic                  ram_en;
    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] inc_val;

    // leading one at bit len, pattern bits below it
    function automatic logic [AW-1:0] f_slot(input logic [LEN_W-1:0] len,
                                             input logic [MAX_LEN-1:0] bits);
        logic [AW-1:0] s;
        s = '0;
        for (int i = 0; i < MAX_LEN; i++) begin
            s[i] = (LEN_W'(i) < len) ? bits[i] : (LEN_W'(i) == len);
        end
        s[MAX_LEN] = (len == LEN_W'(MAX_LEN));
        return s;
    endfunction

    assign lo = (r_min_len == '0) ? LEN_W'(1) : LEN_W'(r_min_len);
    assign hi = (LEN_W'(r_max_len) > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN)
                                                     : LEN_W'(r_max_len);
    assign qlen = LEN_W'(i_query_len);

    assign win_ext  = {r_window, i_stream_bit};
    assign n_window = win_ext[MAX_LEN-1:0];
    assign n_seen   = (r_seen == SW'(MAX_LEN)) ? r_seen : r_seen + 1'b1;
    assign seen_len = LEN_W'(n_seen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len   <= MIN_LEN_RST;
            r_max_len   <= MAX_LEN_RST;
            r_window    <= '0;
            r_seen      <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_MIN_LEN) r_min_len <= i_cfg_data;
                if (i_cfg_index == CFG_MAX_LEN) r_max_len <= i_cfg_data;
            end
            if (i_cmd.load_shift) begin
                r_window <= n_window;
                r_seen   <= n_seen;
            end
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_shift) begin
            r_len <= lo;
            r_end <= (hi < seen_len) ? hi : seen_len;
        end else if (i_cmd.inc_wr) begin
            r_len <= r_len + 1'b1;
        end
        if (i_cmd.load_query) begin
            r_qaddr <= f_slot(qlen, MAX_LEN'(i_query_pattern));
            r_q_in  <= (qlen >= lo) && (qlen <= hi);
        end
        if (i_cmd.out_load) r_count <= r_q_in ? ram_rdata : '0;
    end

    // saturating increment of the count just read
    assign inc_val = (&ram_rdata) ? ram_rdata : ram_rdata + 1'b1;

    always_comb begin
        ram_en    = i_cmd.clr_step | i_cmd.inc_rd | i_cmd.inc_wr | i_cmd.q_rd;
        ram_we    = i_cmd.clr_step | i_cmd.inc_wr;
        ram_wdata = i_cmd.clr_step ? '0 : inc_val;
        if (i_cmd.clr_step) begin
            ram_addr = r_clr_addr;
        end else if (i_cmd.q_rd) begin
            ram_addr = r_qaddr;
        end else begin
            ram_addr = f_slot(r_len, r_window);
        end
    end

    bnh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_stat.clr_last = &r_clr_addr;
    assign o_stat.len_ok   = (r_len <= r_end);
    assign o_stat.len_last = (r_len == r_end);
    assign o_stat.out_busy = r_out_valid && !i_ready;

    assign o_valid         = r_out_valid;
    assign o_pattern_count = r_count;

endmodule

// ===== src/bit_ngram_histogram.sv =====
// bit n-gram histogram
// input channel (i_valid / o_ready): i_opcode selects a shift of i_stream_bit
// into the window or a count read of (i_query_len, i_query_pattern).
// a shift counts every pattern of length min_len..max_len (capped at MAX_LEN
// and at the bits seen so far) ending at the new bit, one read-modify-write
// of the single-port count memory per length, in a read state and then a
// write state; when no length is counted it goes back to idle from the read state.
// a read passes through a memory read state and an output state, which loads
// o_pattern_count and raises o_valid; shifts produce no result; the next item
// can be taken once the block is back in idle.
// the result sits in an output register; while the receiver stalls, shifts
// keep being taken, and a second read waits before loading that register.
// config port (i_cfg_valid / o_cfg_ready, always ready): index 0 min_len,
// index 1 max_len; write only while the block is idle.
// after reset o_ready stays low while all 2^(MAX_LEN+1) entries of the count
// memory (8192 by default) are swept to zero; config writes are still taken.
module bit_ngram_histogram #(
    parameter int MAX_LEN = 12,
    parameter int COUNT_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bnh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bnh_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_opcode,
    input  logic                          i_stream_bit,
    input  logic [bnh_pkg::QLEN_W-1:0]    i_query_len,
    input  logic [bnh_pkg::QPAT_W-1:0]    i_query_pattern,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [COUNT_BITS-1:0]         o_pattern_count
);

    import bnh_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    bnh_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    bnh_datapath #(
        .MAX_LEN    (MAX_LEN),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_stream_bit    (i_stream_bit),
        .i_query_len     (i_query_len),
        .i_query_pattern (i_query_pattern),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pattern_count (o_pattern_count)
    );

    // a read into an empty output register is presented after the memory read and output states
    a_query_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_opcode == OP_QUERY) && !o_valid) |=> ##2 o_valid)
        else $error("read transfer did not produce a result in time");

    // a shift never creates a result
    a_shift_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_opcode == OP_SHIFT) && !o_valid) |=> !o_valid)
        else $error("shift transfer produced a result");

    // memory sweep holds off input right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_ready)
        else $error("input taken before the count memory was cleared");

    // the memory never gets two of its commands (clear, increment read or write, read) in the same cycle
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr_step, cmd.inc_rd, cmd.inc_wr, cmd.q_rd}))
        else $error("conflicting count memory commands");

endmodule
